@@ sv/best_fit_span_allocator_assert.svh @@
// Assertion macros used by the allocator.
`ifndef BEST_FIT_SPAN_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SPAN_ALLOCATOR_ASSERT_SVH

// Assert that an implication holds at every clock edge outside reset.
`define BFSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that an implication holds in the cycle after its antecedent.
`define BFSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/bfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfsa_pkg
// Types and constants of the best-fit span allocator.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int unsigned DefMaxFreeRuns = 64;
  localparam int unsigned DefIndexBits   = 16;
  localparam int unsigned LenW   = 17;
  localparam int unsigned StartW = 16;
  localparam int unsigned StampW = 32;
  localparam logic [LenW-1:0] LenMax = '1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZero    = 2'd1,
    StNoFit   = 2'd2,
    StFull    = 2'd3
  } status_e;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  localparam logic [0:0] RegCapacity = 1'b0;

endpackage

@@ sv/bfsa_req_if.sv @@
// ----------------------------------------------------------------------------
// bfsa_req_if
// Request channel: command, count and start.
// ----------------------------------------------------------------------------
interface bfsa_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [16:0] span_count;
  logic [15:0] span_start;

  modport source (output valid, cmd, span_count, span_start, input ready);
  modport sink (input valid, cmd, span_count, span_start, output ready);
endinterface

@@ sv/bfsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bfsa_rsp_if
// Response channel: status, grant and free total.
// ----------------------------------------------------------------------------
interface bfsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] granted_start;
  logic [16:0] granted_count;
  logic [16:0] free_total;

  modport source (output valid, status, granted_start, granted_count, free_total,
                  input ready);
  modport sink (input valid, status, granted_start, granted_count, free_total,
                output ready);
endinterface

@@ sv/bfsa_run_mem.sv @@
// ----------------------------------------------------------------------------
// bfsa_run_mem
// Run table memory: start, length and stamp per entry, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
module bfsa_run_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [bfsa_pkg::StartW-1:0] wstart_i,
  input  logic [bfsa_pkg::LenW-1:0]   wlen_i,
  input  logic [bfsa_pkg::StampW-1:0] wstamp_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [bfsa_pkg::StartW-1:0] rstart_o,
  output logic [bfsa_pkg::LenW-1:0]   rlen_o,
  output logic [bfsa_pkg::StampW-1:0] rstamp_o
);
  import bfsa_pkg::*;

  logic [StartW+LenW+StampW-1:0] mem_q [Depth];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= {wstart_i, wlen_i, wstamp_i};
    end
    {rstart_o, rlen_o, rstamp_o} <= mem_q[raddr_i];
  end
endmodule

@@ sv/best_fit_span_allocator.sv @@
// ----------------------------------------------------------------------------
// best_fit_span_allocator
// The allocator keeps up to MAX_FREE_RUNS free runs in one memory with a
// valid bit per entry in flip-flops. Every request with a nonzero count scans
// the table through the read port, one entry per cycle while no capacity
// write arrives. A free then passes through the decision and apply states
// before its result word is offered; a free whose start already heads a run
// and an allocate that finds no run skip the apply state. An allocate that
// finds a run makes a second pass to check whether the remainder start
// already heads another run, then applies the update. A zero count offers its
// result on the cycle after acceptance. The result word waits in an output
// register, and the next request is taken on the cycle after it has been
// delivered, so stalls on the response side add cycle for cycle. Reset and a
// capacity write restart the table as one run of the clamped capacity, or
// empty for zero; after reset the first request waits for the initial write.
// ----------------------------------------------------------------------------
module best_fit_span_allocator #(
  parameter int unsigned MAX_FREE_RUNS = bfsa_pkg::DefMaxFreeRuns,
  parameter int unsigned INDEX_BITS    = bfsa_pkg::DefIndexBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bfsa_req_if.sink    req,
  bfsa_rsp_if.source  rsp
);
  import bfsa_pkg::*;
`include "best_fit_span_allocator_assert.svh"

  localparam int unsigned AW = (MAX_FREE_RUNS > 1) ? $clog2(MAX_FREE_RUNS) : 1;
  localparam int unsigned IW = (INDEX_BITS < StartW) ? INDEX_BITS : StartW;
  localparam logic [AW:0] LastIdx = (AW+1)'(MAX_FREE_RUNS - 1);
  localparam logic [LenW:0] CapLim = (LenW+1)'(1) << IW;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SScan  = 6'b000010,
    SDec   = 6'b000100,
    SScan2 = 6'b001000,
    SApply = 6'b010000,
    SOut   = 6'b100000
  } state_e;

  // Configuration register.
  logic [LenW-1:0] cap_q;
  logic cfg_wr;
  logic init_q;
  assign cfg_wr = psel & penable & pwrite & (paddr == {RegCapacity, 1'b0});
  assign pready = 1'b1;
  assign prdata = (paddr == {RegCapacity, 1'b0}) ? 32'(cap_q) : '0;

  // Clamped capacity used when the table restarts.
  logic [LenW:0] cap_cl;
  logic [LenW-1:0] new_cap;
  assign new_cap = cfg_wr ? pwdata[LenW-1:0] : cap_q;
  assign cap_cl = ({1'b0, new_cap} > CapLim) ? CapLim : {1'b0, new_cap};

  state_e st_q;
  logic [MAX_FREE_RUNS-1:0] vld_q;
  logic [StampW-1:0] stamp_q;
  logic [LenW-1:0] free_q;
  logic cmd_q;
  logic [LenW-1:0] cnt_q;
  logic [StartW-1:0] s_q;
  logic [AW:0] ridx_q, cidx_q;   // read address, and address of data on port
  logic rv_q;
  // Scan results.
  logic best_f_q, prev_f_q, next_f_q, hit_q, empty_f_q;
  logic [AW-1:0] best_q, prev_q, next_q, empty_q;
  logic [StartW-1:0] b_start_q, p_start_q, n_start_q;
  logic [LenW-1:0] b_len_q, p_len_q, n_len_q;
  logic [StampW-1:0] b_stamp_q;
  logic rem_hit_q;
  logic [StartW-1:0] rem_start_q;
  logic [1:0] ost_q;
  logic [StartW-1:0] ogs_q;
  logic [LenW-1:0] ogc_q;

  logic we;
  logic [AW-1:0] waddr;
  logic [StartW-1:0] wstart;
  logic [LenW-1:0] wlen;
  logic [StartW-1:0] rstart;
  logic [LenW-1:0] rlen;
  logic [StampW-1:0] rstamp;
  logic init_we;

  bfsa_run_mem #(.Depth(MAX_FREE_RUNS), .AddrW(AW)) u_mem (
    .clk_i, .we_i(we | init_we), .waddr_i(init_we ? '0 : waddr),
    .wstart_i(init_we ? '0 : wstart),
    .wlen_i(init_we ? cap_cl[LenW-1:0] : wlen),
    .wstamp_i(init_we ? '0 : stamp_q), .raddr_i(ridx_q[AW-1:0]),
    .rstart_o(rstart), .rlen_o(rlen), .rstamp_o(rstamp)
  );
  // The initial run is written into the memory after reset and on a capacity write.
  assign init_we = cfg_wr | init_q;

  assign req.ready = (st_q == SIdle) && !init_q;
  assign rsp.valid = (st_q == SOut);
  assign rsp.status = ost_q;
  assign rsp.granted_start = ogs_q;
  assign rsp.granted_count = ogc_q;
  assign rsp.free_total = free_q;

  logic cur_v;
  logic [AW-1:0] cur;
  assign cur = cidx_q[AW-1:0];
  assign cur_v = rv_q & vld_q[cur];

  // Decision logic from the scan results.
  logic [StartW-1:0] ns_alloc;
  logic [LenW-1:0] rem;
  logic pm, nm;
  logic [LenW+1:0] nsum;
  assign ns_alloc = StartW'(({1'b0, b_start_q} + StartW'(cnt_q)) & ((17'd1 << IW) - 17'd1));
  assign rem = b_len_q - cnt_q;
  assign pm = prev_f_q && ({2'b0, p_start_q} + {1'b0, p_len_q}) == {2'b0, s_q};
  assign nm = next_f_q && ({2'b0, s_q} + {1'b0, cnt_q}) == {2'b0, n_start_q};
  assign nsum = {2'b0, cnt_q} + (pm ? {2'b0, p_len_q} : '0) + (nm ? {2'b0, n_len_q} : '0);

  always_comb begin
    we = 1'b0;
    waddr = best_q;
    wstart = ns_alloc;
    wlen = rem;
    if (st_q == SApply) begin
      if (cmd_q == CmdAlloc) begin
        we = (rem != '0) && !rem_hit_q;
      end else begin
        we = pm | nm | empty_f_q;
        waddr = pm ? prev_q : (nm ? next_q : empty_q);
        wstart = pm ? p_start_q : s_q;
        wlen = (nsum > {2'b0, LenMax}) ? LenMax : nsum[LenW-1:0];
      end
    end
  end

  logic [LenW:0] fsum;
  assign fsum = {1'b0, free_q} + {1'b0, cnt_q};

  // Sequencer: scans the table through the read port and applies the update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      cap_q <= 17'h10000;
      init_q <= 1'b1;
      vld_q <= MAX_FREE_RUNS'(1);
      stamp_q <= 32'd1;
      free_q <= 17'h10000;
      ridx_q <= '0; cidx_q <= '0; rv_q <= 1'b0;
      ost_q <= StOk;
    end else if (cfg_wr || init_q) begin
      cap_q <= new_cap;
      init_q <= 1'b0;
      vld_q <= MAX_FREE_RUNS'(cap_cl != '0);
      stamp_q <= 32'd1;
      free_q <= cap_cl[LenW-1:0];
    end else begin
      unique case (st_q)
        SIdle: if (req.valid) begin
          cmd_q <= req.cmd; cnt_q <= req.span_count;
          s_q <= req.span_start & StartW'((17'd1 << IW) - 17'd1);
          best_f_q <= 1'b0; prev_f_q <= 1'b0; next_f_q <= 1'b0;
          hit_q <= 1'b0; empty_f_q <= 1'b0;
          ogs_q <= '0; ogc_q <= '0;
          ridx_q <= '0; rv_q <= 1'b0;
          if (req.span_count == '0) begin
            ost_q <= StZero; st_q <= SOut;
          end else begin
            st_q <= SScan;
          end
        end
        SScan, SScan2: begin
          cidx_q <= ridx_q;
          ridx_q <= ridx_q + 1'b1;
          if (!cur_v && rv_q && !empty_f_q) begin
            empty_f_q <= 1'b1; empty_q <= cur;
          end
          if (cur_v && st_q == SScan) begin
            if (cmd_q == CmdAlloc) begin
              if (rlen >= cnt_q && (!best_f_q || rlen < b_len_q ||
                  (rlen == b_len_q && rstamp < b_stamp_q))) begin
                best_f_q <= 1'b1; best_q <= cur; b_start_q <= rstart;
                b_len_q <= rlen; b_stamp_q <= rstamp;
              end
            end else begin
              if (rstart == s_q) hit_q <= 1'b1;
              if (rstart < s_q) begin
                if (!prev_f_q || rstart > p_start_q) begin
                  prev_f_q <= 1'b1; prev_q <= cur; p_start_q <= rstart; p_len_q <= rlen;
                end
              end else if (!next_f_q || rstart < n_start_q) begin
                next_f_q <= 1'b1; next_q <= cur; n_start_q <= rstart; n_len_q <= rlen;
              end
            end
          end
          // Second pass: look for a valid run heading the remainder start.
          if (cur_v && st_q == SScan2 && cur != best_q && rstart == rem_start_q) begin
            rem_hit_q <= 1'b1;
          end
          if (rv_q && cidx_q == LastIdx) begin
            st_q <= (st_q == SScan) ? SDec : SApply;
            rv_q <= 1'b0;
          end else begin
            rv_q <= (ridx_q <= LastIdx);
          end
        end
        SDec: begin
          if (cmd_q == CmdAlloc) begin
            if (!best_f_q) begin
              ost_q <= StNoFit; st_q <= SOut;
            end else begin
              rem_start_q <= ns_alloc; rem_hit_q <= 1'b0;
              ridx_q <= '0; st_q <= SScan2;
            end
          end else if (hit_q) begin
            ost_q <= StOk; st_q <= SOut;
          end else begin
            st_q <= SApply;
          end
        end
        SApply: begin
          st_q <= SOut;
          if (cmd_q == CmdAlloc) begin
            ost_q <= StOk;
            ogs_q <= b_start_q; ogc_q <= cnt_q;
            free_q <= (free_q >= cnt_q) ? free_q - cnt_q : '0;
            vld_q[best_q] <= (rem != '0) && !rem_hit_q;
            if (we) stamp_q <= stamp_q + 1'b1;
          end else if (!we) begin
            ost_q <= StFull;
          end else begin
            ost_q <= StOk;
            vld_q[waddr] <= 1'b1;
            if (pm && nm) vld_q[next_q] <= 1'b0;
            stamp_q <= stamp_q + 1'b1;
            free_q <= fsum[LenW] ? LenMax : fsum[LenW-1:0];
          end
        end
        SOut: if (rsp.ready) st_q <= SIdle;
        default: st_q <= SIdle;
      endcase
    end
  end

  // Checks on the sequencer.
  `BFSA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, req.ready, !rsp.valid)
  `BFSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, rsp.valid && !rsp.ready && !cfg_wr,
                    rsp.valid)
  `BFSA_ASSERT_IMP(a_grant_ok, clk_i, rst_ni, rsp.valid && ogc_q != '0, ost_q == StOk)
endmodule

@@ tb/sv/span_alloc_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// span_alloc_checker
// Watches the request and response channels and the register port of the
// span allocator, keeps its own copy of the free-run table, predicts the
// response word of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module span_alloc_checker
  import bfsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  bfsa_req_if         req,
  bfsa_rsp_if         rsp,
  output int          fail_count,
  output int          pending_count
);

  localparam int Runs = 64;

  typedef struct packed {
    status_e     status;
    logic [15:0] gstart;
    logic [16:0] gcount;
    logic [16:0] total;
  } rsp_word_t;

  logic [16:0] cap_q;
  logic [15:0] run_start_q [Runs];
  logic [16:0] run_len_q [Runs];
  logic        run_vld_q [Runs];
  logic [31:0] run_stamp_q [Runs];
  logic [31:0] stamp_q;
  logic [16:0] free_q;
  rsp_word_t   expected_words [$];

  assign pending_count = expected_words.size();

  // Restart the table as one run covering the capacity clamped to 65536, or empty for zero.
  task automatic restart_table();
    logic [16:0] c;
    c = (cap_q > 17'd65536) ? 17'd65536 : cap_q;
    for (int i = 0; i < Runs; i++) begin
      run_vld_q[i] = 1'b0;
      run_start_q[i] = '0;
      run_len_q[i] = '0;
      run_stamp_q[i] = '0;
    end
    free_q = c;
    if (c != 0) begin
      run_vld_q[0] = 1'b1;
      run_len_q[0] = c;
    end
    stamp_q = 32'd1;
  endtask

  function automatic int heads_run(logic [15:0] s);
    for (int i = 0; i < Runs; i++)
      if (run_vld_q[i] && run_start_q[i] == s) return i;
    return -1;
  endfunction

  task automatic place_run(int e, logic [15:0] s, logic [16:0] len);
    run_vld_q[e] = 1'b1;
    run_start_q[e] = s;
    run_len_q[e] = len;
    run_stamp_q[e] = stamp_q;
    stamp_q = stamp_q + 32'd1;
  endtask

  // Apply one request to the table and return the response it gives.
  task automatic serve_request(input logic cmd, input logic [16:0] cnt,
                               input logic [15:0] s, output rsp_word_t w);
    int best, prev, next, tgt;
    bit pm, nm;
    logic [15:0] nstart;
    logic [18:0] nlen;
    w = '{status: StOk, gstart: '0, gcount: '0, total: '0};
    if (cnt == 0) begin
      w.status = StZero;
    end else if (cmd == CmdAlloc) begin
      best = -1;
      for (int i = 0; i < Runs; i++) begin
        if (!run_vld_q[i] || run_len_q[i] < cnt) continue;
        if (best < 0 || run_len_q[i] < run_len_q[best] ||
            (run_len_q[i] == run_len_q[best] && run_stamp_q[i] < run_stamp_q[best]))
          best = i;
      end
      if (best < 0) begin
        w.status = StNoFit;
      end else begin
        w.gstart = run_start_q[best];
        w.gcount = cnt;
        run_vld_q[best] = 1'b0;
        if (run_len_q[best] != cnt) begin
          nstart = w.gstart + cnt[15:0];
          if (heads_run(nstart) < 0) place_run(best, nstart, run_len_q[best] - cnt);
        end
        free_q = (free_q >= cnt) ? free_q - cnt : '0;
      end
    end else if (heads_run(s) < 0) begin
      prev = -1;
      next = -1;
      for (int i = 0; i < Runs; i++) begin
        if (!run_vld_q[i]) continue;
        if (run_start_q[i] < s) begin
          if (prev < 0 || run_start_q[i] > run_start_q[prev]) prev = i;
        end else begin
          if (next < 0 || run_start_q[i] < run_start_q[next]) next = i;
        end
      end
      pm = prev >= 0 && ({2'b0, run_start_q[prev]} + {1'b0, run_len_q[prev]}) == {2'b0, s};
      nm = next >= 0 && ({2'b0, s} + {1'b0, cnt}) == {2'b0, run_start_q[next]};
      if (pm) tgt = prev;
      else if (nm) tgt = next;
      else begin
        tgt = -1;
        for (int i = 0; i < Runs; i++)
          if (tgt < 0 && !run_vld_q[i]) tgt = i;
      end
      if (tgt < 0) begin
        w.status = StFull;
      end else begin
        nstart = s;
        nlen = {2'b0, cnt};
        if (pm) begin
          nstart = run_start_q[prev];
          nlen += {2'b0, run_len_q[prev]};
        end
        if (nm) begin
          nlen += {2'b0, run_len_q[next]};
          if (pm) run_vld_q[next] = 1'b0;
        end
        place_run(tgt, nstart, (nlen > 19'h1FFFF) ? 17'h1FFFF : nlen[16:0]);
        free_q = ({1'b0, free_q} + cnt > 18'h1FFFF) ? 17'h1FFFF : free_q + cnt;
      end
    end
    w.total = free_q;
  endtask

  // Track register writes and requests, and compare responses.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_word_t w, e;
    if (!rst_ni) begin
      cap_q = 17'd65536;
      restart_table();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == 2'd0) begin
        cap_q = pwdata[16:0];
        restart_table();
      end
      if (req.valid && req.ready) begin
        serve_request(req.cmd, req.span_count, req.span_start, w);
        expected_words.push_back(w);
      end
      if (rsp.valid && rsp.ready) begin
        w = '{status: status_e'(rsp.status), gstart: rsp.granted_start,
              gcount: rsp.granted_count, total: rsp.free_total};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected response word %h", w);
        end else begin
          e = expected_words.pop_front();
          if (w != e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: st %0d/%0d start %0d/%0d count %0d/%0d total %0d/%0d",
                       e.status, w.status, e.gstart, w.gstart, e.gcount, w.gcount,
                       e.total, w.total);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_best_fit_span_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_best_fit_span_allocator
// Drives directed and random allocate/free requests with random gaps and
// stalls through several capacity settings; the checker predicts responses.
// ----------------------------------------------------------------------------
module tb_best_fit_span_allocator;
  import bfsa_pkg::*;

  localparam int Quiet = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending_count, idle_cycles;
  bit          hold_off = 1'b0;
  bit          no_gaps = 1'b0;
  logic [15:0] owned_start [$];
  logic [16:0] owned_count [$];

  bfsa_req_if req ();
  bfsa_rsp_if rsp ();

  best_fit_span_allocator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .req(req.sink), .rsp(rsp.source)
  );

  span_alloc_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .req(req), .rsp(rsp), .fail_count, .pending_count
  );

  always #5 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0;
    req.cmd = CmdAlloc;
    req.span_count = '0;
    req.span_start = '0;
    rsp.ready = 1'b0;
  end

  // Response side: random stalls unless held off or in a no-gap stretch.
  always @(posedge clk_i) begin
    rsp.ready <= !hold_off && (no_gaps || $urandom_range(99) >= 10);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Quiet) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_capacity(logic [16:0] c);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {RegCapacity, 1'b0} * 2'd2;
    pwdata <= {15'd0, c};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    owned_start.delete();
    owned_count.delete();
  endtask

  task automatic send(logic cmd, logic [16:0] cnt, logic [15:0] s);
    @(posedge clk_i);
    while (!no_gaps && $urandom_range(99) < 10) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.span_count <= cnt;
    req.span_start <= s;
    do @(posedge clk_i); while (!req.ready);
    req.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // One random request: mostly allocates and frees, with free counts bounded by owned counts.
  task automatic random_request(int cap);
    int k;
    logic [16:0] c;
    k = $urandom_range(99);
    if (k < 45) begin
      c = ($urandom_range(9) == 0) ? 17'($urandom_range(cap + 2))
                                   : 17'($urandom_range(1, 64));
      send(CmdAlloc, c, 16'($urandom));
      owned_start.push_back(16'($urandom));
      owned_count.push_back(c);
    end else if (k < 85 && owned_start.size() > 0) begin
      k = $urandom_range(owned_start.size() - 1);
      c = 17'($urandom_range(1, owned_count[k] == 0 ? 1 : owned_count[k]));
      send(CmdFree, c, 16'($urandom_range(cap)));
      owned_start.delete(k);
      owned_count.delete(k);
    end else begin
      send(1'($urandom), 17'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int caps [5];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, both operations, zero count, heading start, no fit.
    send(CmdAlloc, 17'd0, 16'hFFFF);
    send(CmdFree, 17'd0, 16'd0);
    send(CmdAlloc, 17'd65536, 16'd0);
    send(CmdAlloc, 17'd1, 16'd0);
    send(CmdFree, 17'd10, 16'd100);
    send(CmdFree, 17'd10, 16'd100);
    send(CmdFree, 17'h1FFFF, 16'hFFFF);
    send(CmdAlloc, 17'd16, 16'h0);
    send(CmdAlloc, 17'd4, 16'h0);
    send(CmdFree, 17'd4, 16'd10);
    send(CmdFree, 17'd6, 16'd4);
    send(CmdFree, 17'd1, 16'hFFFF);
    send(CmdAlloc, 17'h1FFFF, 16'h0);
    drain();

    // Table full: many isolated single-slot frees into an empty table.
    write_capacity(17'd1);
    send(CmdAlloc, 17'd1, 16'd0);
    for (int i = 0; i < 66; i++) send(CmdFree, 17'd1, 16'(2 * i + 4));
    drain();

    caps = '{17'd0, 17'd65536, 17'h1FFFF, 17'd300, 17'd64};
    foreach (caps[p]) begin
      write_capacity(17'(caps[p]));
      for (int n = 0; n < 95; n++) begin
        if (p == 1 && n == 20) no_gaps = 1'b1;
        if (p == 1 && n == 60) no_gaps = 1'b0;
        // Stall the response side long enough for the input to back up.
        if (p == 2 && n == 30) fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
        if (p == 3 && n == 50) while (pending_count != 0) @(posedge clk_i);
        random_request(caps[p] > 65536 ? 65536 : caps[p]);
      end
      drain();
    end

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
